// ===== design/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, request codes and control structs for the sorted table
// search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 11;
  localparam int POS_W   = 10;

  // Stream packing
  localparam int IN_RAW_W  = SLOT_W + VALUE_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 1 + POS_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_RAW_W;

  // Request codes carried in tuser
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ANY   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIRST = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch key and mode, open the search window
    logic first;     // first-match mode, valid with start
    logic step;      // evaluate the probe data of the current midpoint
    logic wr;        // write the request's value into the table
    logic load_out;  // move the answer into the output register
  } stbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic live_next; // another probe follows this cycle's update
    logic out_free;  // output register can take an answer this cycle
  } stbs_sts_t;

endpackage

// ===== design/sorted_table_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Binary search over a table of signed 32-bit entries kept in ascending order.
// ----------------------------------------------------------------------------
// Software loads the table with write requests (tuser = write) and sets the
// number of entries in use through cfg_wen/cfg_wdata, only while the core is
// idle. A search request (tuser = any-match or first-match) looks the key up
// among slots 0 .. entry_count-1 and returns one result: found and position,
// position zero on a miss. Any-match reports the first probe that hits, using
// the floor midpoint; first-match keeps narrowing left and reports the lowest
// index holding the key. Writes and the unused request code give no result.
// Timing: a write is stored as it is taken. A search makes P probes, P being
// at most ceil(log2(entry_count + 1)); the table RAM's registered read port
// delivers one probe a cycle. One request is in flight at a time; a
// finished answer waits in the output register while the next request is
// taken. Entries never written hold no defined value and must not be probed.
// Clipping: an entry_count above the table depth is taken as the depth; a
// write to a slot beyond the depth is dropped.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: entry_count
  input  logic                              cfg_wen,
  input  logic [stbs_pkg::CFG_W-1:0]        cfg_wdata,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stbs_pkg::IN_DATA_W-1:0]    s_tdata,   // slot[9:0], item_value[41:10], zero
  input  logic [stbs_pkg::FUNC_W-1:0]       s_tuser,   // func[1:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stbs_pkg::OUT_DATA_W-1:0]   m_tdata    // found[0], position[10:1], zero
);

  stbs_pkg::stbs_cmd_t cmd;
  stbs_pkg::stbs_sts_t sts;

  logic [stbs_pkg::SLOT_W-1:0]         slot;
  logic signed [stbs_pkg::VALUE_W-1:0] item_value;

  // unpack the request
  assign slot       = s_tdata[stbs_pkg::SLOT_W-1:0];
  assign item_value = s_tdata[stbs_pkg::IN_RAW_W-1:stbs_pkg::SLOT_W];

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  stbs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .slot       (slot),
    .item_value (item_value),
    .cmd        (cmd),
    .sts        (sts),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ===== design/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// Request sequencer: takes requests when idle, steps the probe loop and
// hands the answer to the output register.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [stbs_pkg::FUNC_W-1:0]   func,
  input  stbs_pkg::stbs_sts_t           sts,
  output stbs_pkg::stbs_cmd_t           cmd
);

  typedef enum logic [1:0] {
    IDLE,
    PROBE,
    FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        if (accept) begin
          cmd.wr    = (func == stbs_pkg::FUNC_WRITE);
          cmd.start = func inside {stbs_pkg::FUNC_ANY, stbs_pkg::FUNC_FIRST};
          cmd.first = (func == stbs_pkg::FUNC_FIRST);
        end
      end
      PROBE:   cmd.step     = 1'b1;
      FINISH:  cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.start) begin
            state <= sts.live_next ? PROBE : FINISH;
          end
        end
        PROBE: begin
          if (!sts.live_next) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (sts.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== design/stbs_dp.sv =====
// ----------------------------------------------------------------------------
// stbs_dp
// Search datapath: entry count register, table RAM, search window,
// midpoint and compare, output register.
// ----------------------------------------------------------------------------
module stbs_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [stbs_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [stbs_pkg::SLOT_W-1:0]           slot,
  input  logic signed [stbs_pkg::VALUE_W-1:0]   item_value,
  input  stbs_pkg::stbs_cmd_t                   cmd,
  output stbs_pkg::stbs_sts_t                   sts,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [stbs_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int AW = stbs_pkg::ADDR_W;
  localparam int CW = stbs_pkg::CNT_W;

  logic [stbs_pkg::CFG_W-1:0]          entry_count;
  logic [CW-1:0]                       n_eff;

  logic signed [stbs_pkg::VALUE_W-1:0] key;
  logic                                first;
  logic [CW-1:0]                       lo, lo_next;
  logic [CW-1:0]                       up, up_next;     // exclusive upper bound
  logic                                stop, stop_next;
  logic [AW-1:0]                       mid, mid_next;
  logic [AW-1:0]                       hit, hit_next;
  logic                                found, found_next;
  logic [CW-1:0]                       span;
  logic [CW-1:0]                       mid_sum;

  logic                                ram_we;
  logic signed [stbs_pkg::VALUE_W-1:0] probe;
  logic                                eq;
  logic                                gt;

  logic                                out_found;
  logic [stbs_pkg::POS_W-1:0]          out_pos;

  // Counts above the table size are clipped to it
  assign n_eff = (32'(entry_count) > 32'(stbs_pkg::TABLE_DEPTH)) ?
                 CW'(stbs_pkg::TABLE_DEPTH) : CW'(entry_count);

  assign ram_we = cmd.wr && (32'(slot) < 32'(stbs_pkg::TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (stbs_pkg::VALUE_W),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(slot)),
    .wdata (item_value),
    .raddr (mid_next),
    .rdata (probe)
  );

  assign eq = (probe == key);
  assign gt = (key > probe);

  always_comb begin
    lo_next    = lo;
    up_next    = up;
    stop_next  = stop;
    hit_next   = hit;
    found_next = found;
    if (cmd.start) begin
      lo_next    = '0;
      up_next    = n_eff;
      stop_next  = 1'b0;
      hit_next   = '0;
      found_next = 1'b0;
    end else if (cmd.step) begin
      if (eq) begin
        hit_next   = mid;
        found_next = 1'b1;
        if (first) begin
          up_next = CW'(mid);   // keep narrowing to the left
        end else begin
          stop_next = 1'b1;
        end
      end else if (gt) begin
        lo_next = CW'(mid) + CW'(1);
      end else begin
        up_next = CW'(mid);
      end
    end
    // floor midpoint lo + (hi - lo) / 2, hi = up - 1
    span     = up_next - lo_next - CW'(1);
    mid_sum  = lo_next + (span >> 1);
    mid_next = mid_sum[AW-1:0];
  end

  assign sts.live_next = (lo_next < up_next) && !stop_next;
  assign sts.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        entry_count <= cfg_wdata;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo    <= lo_next;
    up    <= up_next;
    stop  <= stop_next;
    hit   <= hit_next;
    found <= found_next;
    mid   <= mid_next;
    if (cmd.start) begin
      key   <= item_value;
      first <= cmd.first;
    end
    if (cmd.load_out) begin
      out_found <= found;
      out_pos   <= stbs_pkg::POS_W'(hit);
    end
  end

  assign m_tdata = {{stbs_pkg::OUT_PAD_W{1'b0}}, out_pos, out_found};

endmodule

// ===== design/stbs_chk.sv =====
// ----------------------------------------------------------------------------
// stbs_chk
// Port-level checks for the search core, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [stbs_pkg::FUNC_W-1:0]       s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [stbs_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[stbs_pkg::POS_W:1] == '0)
    else $error("miss with non-zero position");

  // a search keeps the core busy for at least the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == stbs_pkg::FUNC_ANY || s_tuser == stbs_pkg::FUNC_FIRST)
    |=> !s_tready)
    else $error("request taken during a search");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_table_binary_search_core stbs_chk u_chk (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted table binary search core.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty table, the reset count,
// the unused request code, both value extremes and the top slot. The random
// part follows it as phases. Each phase loads a table (sorted with dense
// duplicates, sparse, crowded at the top, or unsorted), sets entry_count once
// the core has drained, and then mixes searches of both modes with window
// writes, out-of-window writes and unused codes. One phase fills all 1024
// slots and the next sets the count to its 11-bit maximum. A shadow copy of
// table and count predicts every answer. Both stream sides idle in short
// random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE_CYCLES = 20;    // longer than a full-depth search
  localparam int RANDOM_ITEMS  = 1950;
  localparam int QUIET_AFTER   = 1700;  // no idling past this many requests

  localparam logic [stbs_pkg::FUNC_W-1:0]  FUNC_SPARE = 2'd3;  // unused code
  localparam logic [stbs_pkg::VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [stbs_pkg::VALUE_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                       found;
    logic [stbs_pkg::POS_W-1:0] position;
  } answer_t;

  localparam answer_t MISS        = '{1'b0, 10'd0};
  localparam answer_t HIT_AT_ZERO = '{1'b1, 10'd0};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [stbs_pkg::FUNC_W-1:0]  func;
    logic [stbs_pkg::SLOT_W-1:0]  slot;
    logic [stbs_pkg::VALUE_W-1:0] value;   // entry_count on a config row
    logic                         typed;   // answer below is fixed, not predicted
    answer_t                      want;
  } stim_row_t;

  // Directed stimulus. Slots 0..5 end up holding MIN, 7, 7, 7, 9, MAX, so
  // any-match and first-match part ways on key 7.
  stim_row_t directed_rows [23] = '{
    '{ROW_REQ, stbs_pkg::FUNC_ANY,   10'd0,    32'd0,         1'b1, MISS},  // reset count
    '{ROW_REQ, stbs_pkg::FUNC_FIRST, 10'd1023, VAL_MIN,       1'b1, MISS},
    '{ROW_REQ, FUNC_SPARE,           10'h2AA,  32'h5555_AAAA, 1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd0,    VAL_MIN,       1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd1,    32'd7,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd2,    32'd7,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd3,    32'd7,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd4,    32'd9,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd5,    VAL_MAX,       1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_WRITE, 10'd1023, 32'hFFFF_FFFF, 1'b0, MISS},  // top slot
    '{ROW_REQ, stbs_pkg::FUNC_ANY,   10'd0,    32'd7,         1'b1, MISS},  // count still 0
    '{ROW_CFG, stbs_pkg::FUNC_WRITE, 10'd0,    32'd6,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_ANY,   10'd0,    32'd7,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_FIRST, 10'd0,    32'd7,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_ANY,   10'd0,    VAL_MIN,       1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_FIRST, 10'd0,    VAL_MAX,       1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_ANY,   10'd0,    32'd8,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_FIRST, 10'd0,    32'hFFFF_FFFF, 1'b0, MISS},  // outside window
    '{ROW_CFG, stbs_pkg::FUNC_WRITE, 10'd0,    32'd1,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_ANY,   10'd0,    VAL_MIN,       1'b1, HIT_AT_ZERO},
    '{ROW_REQ, stbs_pkg::FUNC_FIRST, 10'd0,    32'd7,         1'b0, MISS},
    '{ROW_CFG, stbs_pkg::FUNC_WRITE, 10'd0,    32'd0,         1'b0, MISS},
    '{ROW_REQ, stbs_pkg::FUNC_FIRST, 10'd0,    VAL_MIN,       1'b1, MISS}   // empty again
  };

  logic                            clk;
  logic                            rst;
  logic                            cfg_wen;
  logic [stbs_pkg::CFG_W-1:0]      cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [stbs_pkg::IN_DATA_W-1:0]  s_tdata;   // slot[9:0], item_value[41:10], zero
  logic [stbs_pkg::FUNC_W-1:0]     s_tuser;   // func[1:0]
  logic                            m_tvalid;
  logic                            m_tready;
  logic [stbs_pkg::OUT_DATA_W-1:0] m_tdata;   // found[0], position[10:1], zero

  // Shadow of the core: table contents and the entry_count register
  logic signed [stbs_pkg::VALUE_W-1:0] shadow_entries [stbs_pkg::TABLE_DEPTH];
  int unsigned                         live_count;
  answer_t                             pending_answers [$];

  answer_t seen_ans;
  answer_t due_ans;
  int      mismatches;
  int      items_sent;
  int      searches_sent;
  int      results_seen;
  int      settings_used;
  int      tx_calm;
  int      rx_calm;
  bit      quiet_tail;

  sorted_table_binary_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Binary search over the shadow table. Leftmost mode keeps narrowing to the
  // left after a hit; otherwise the first probe that hits is the answer.
  function automatic answer_t look_up_key(
      input logic signed [stbs_pkg::VALUE_W-1:0] key,
      input bit leftmost);
    int      n;
    int      lo;
    int      hi;
    int      mid;
    int      hit;
    answer_t ans;
    n   = (live_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : live_count;
    lo  = 0;
    hi  = n - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_entries[mid] == key) begin
        hit = mid;
        if (!leftmost)
          break;
        hi = mid - 1;
      end else if (key > shadow_entries[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    ans = MISS;
    if (hit >= 0) begin
      ans.found    = 1'b1;
      ans.position = hit[stbs_pkg::POS_W-1:0];
    end
    return ans;
  endfunction

  // Drive one request, wait for the handshake, then update the shadow and
  // queue the answer a search is due to give.
  task automatic send_request(input logic [stbs_pkg::FUNC_W-1:0] func,
                              input logic [stbs_pkg::SLOT_W-1:0] slot,
                              input logic [stbs_pkg::VALUE_W-1:0] value,
                              input logic typed,
                              input answer_t typed_ans);
    int gap;
    gap = 0;
    if (!quiet_tail) begin
      if (tx_calm > 0)
        tx_calm--;
      else if ($urandom_range(0, 15) == 0)
        tx_calm = $urandom_range(10, 40);
      else if ($urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= stbs_pkg::IN_DATA_W'({value, slot});
    do @(posedge clk); while (!s_tready);

    if (func != FUNC_SPARE)
      items_sent++;
    case (func)
      stbs_pkg::FUNC_WRITE: shadow_entries[slot] = value;
      stbs_pkg::FUNC_ANY, stbs_pkg::FUNC_FIRST: begin
        searches_sent++;
        if (typed)
          pending_answers.push_back(typed_ans);
        else
          pending_answers.push_back(look_up_key(value, func == stbs_pkg::FUNC_FIRST));
      end
      default: ;  // unused code: no answer
    endcase
  endtask

  // Only written with the core idle: drain answers, then let any write still
  // in flight settle before the register changes.
  task automatic set_entry_count(input int unsigned count);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= count[stbs_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_wen    <= 1'b0;
    live_count = count;
    settings_used++;
  endtask

  // Load slots 0..n-1 in one of several value shapes, in either slot order
  task automatic fill_table(input int n);
    logic [stbs_pkg::VALUE_W-1:0] vals [$];
    longint                       v;
    longint                       step_cap;
    int                           shape;
    int                           j;
    bit                           downward;
    shape    = $urandom_range(0, 5);
    downward = $urandom_range(0, 1);
    if (shape >= 4 && n > 40)
      shape = 3;  // keep big tables sorted
    v        = 0;
    step_cap = -1;
    case (shape)
      0: begin  // dense around zero, many duplicates
        v        = longint'($urandom_range(0, 2000)) - 1000;
        step_cap = 2;
      end
      1: begin  // spread over the whole range from the bottom
        v        = longint'($signed(VAL_MIN));
        step_cap = 64'h1_0000_0000 / (n + 1);
      end
      2: begin  // crowded up against the top
        v        = longint'($signed(VAL_MAX)) - 3 * n;
        step_cap = 3;
      end
      3: begin
        v        = longint'($signed($urandom));
        step_cap = 100;
      end
      default: ;  // unsorted
    endcase
    for (int i = 0; i < n; i++) begin
      if (step_cap < 0) begin
        vals.push_back($urandom);
      end else begin
        vals.push_back(v[stbs_pkg::VALUE_W-1:0]);
        v += $urandom_range(0, step_cap);
        if (v > longint'($signed(VAL_MAX)))
          v = longint'($signed(VAL_MAX));
      end
    end
    for (int i = 0; i < n; i++) begin
      j = downward ? n - 1 - i : i;
      send_request(stbs_pkg::FUNC_WRITE, j[stbs_pkg::SLOT_W-1:0], vals[j], 1'b0, MISS);
    end
  endtask

  // Mostly keys that are present, some neighbours, extremes and noise
  function automatic logic [stbs_pkg::VALUE_W-1:0] pick_key(input int n_eff);
    logic [stbs_pkg::VALUE_W-1:0] base;
    int                           roll;
    roll = $urandom_range(0, 9);
    base = (n_eff > 0) ? shadow_entries[$urandom_range(0, n_eff - 1)] : $urandom;
    if (roll < 6)
      return base;
    if (roll < 8)
      return roll[0] ? base + 1 : base - 1;
    if (roll == 8) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // One table setting: load, set the count, then searches with some writes
  // and unused codes mixed in. Phase 2 fills the whole table and phase 3
  // keeps it with the count at its maximum, which the core clips.
  task automatic run_phase(input int phase_no);
    int                          count;
    int                          n_eff;
    int                          nsrch;
    int                          roll;
    int                          pick;
    logic [stbs_pkg::SLOT_W-1:0] s;
    pick = $urandom_range(0, 15);
    if (phase_no == 2)
      count = stbs_pkg::TABLE_DEPTH;
    else if (phase_no == 3)
      count = (1 << stbs_pkg::CFG_W) - 1;
    else if (pick == 0)
      count = 0;
    else if (pick == 1)
      count = 1;
    else if (pick == 2)
      count = $urandom_range(41, 300);
    else
      count = $urandom_range(2, 40);
    n_eff = (count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : count;
    if (phase_no != 3 && n_eff > 0)
      fill_table(n_eff);
    set_entry_count(count);

    nsrch = (n_eff < 16) ? 2 * n_eff + 8 : 40;
    for (int k = 0; k < nsrch; k++) begin
      if (items_sent >= QUIET_AFTER + $size(directed_rows))
        quiet_tail = 1'b1;
      roll = $urandom_range(0, 29);
      if (roll == 0) begin
        send_request(FUNC_SPARE, stbs_pkg::SLOT_W'($urandom), $urandom, 1'b0, MISS);
      end else if (roll < 4) begin
        if (n_eff < stbs_pkg::TABLE_DEPTH && (n_eff == 0 || $urandom_range(0, 1))) begin
          // outside the window: any value
          s = stbs_pkg::SLOT_W'($urandom_range(n_eff, stbs_pkg::TABLE_DEPTH - 1));
          send_request(stbs_pkg::FUNC_WRITE, s, $urandom, 1'b0, MISS);
        end else begin
          // inside: copy the left neighbour, which keeps the order
          s = stbs_pkg::SLOT_W'($urandom_range(0, n_eff - 1));
          send_request(stbs_pkg::FUNC_WRITE, s,
                       (s > 0) ? shadow_entries[s - 1] : shadow_entries[s],
                       1'b0, MISS);
        end
      end else begin
        send_request($urandom_range(0, 1) ? stbs_pkg::FUNC_FIRST : stbs_pkg::FUNC_ANY,
                     stbs_pkg::SLOT_W'($urandom), pick_key(n_eff), 1'b0, MISS);
      end
    end
  endtask

  // Result side: random ready bursts, with calm stretches
  initial begin
    m_tready = 1'b0;
    rx_calm  = 0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && rx_calm == 0 && $urandom_range(0, 31) == 0) begin
        rx_calm = $urandom_range(20, 80);
      end
      if (rx_calm > 0)
        rx_calm--;
      if (!quiet_tail && rx_calm == 0 && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Every accepted answer against the oldest one due
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_ans.found    = m_tdata[0];
      seen_ans.position = m_tdata[stbs_pkg::POS_W:1];
      results_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("answer with none due: found %0b position %0d",
                                  seen_ans.found, seen_ans.position));
      end else begin
        due_ans = pending_answers.pop_front();
        if (seen_ans.found !== due_ans.found)
          report_mismatch($sformatf("answer %0d: found %0b, due %0b",
                                    results_seen, seen_ans.found, due_ans.found));
        if (seen_ans.position !== due_ans.position)
          report_mismatch($sformatf("answer %0d: position %0d, due %0d",
                                    results_seen, seen_ans.position, due_ans.position));
      end
    end
  end

  initial begin
    int phase_no;
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = stbs_pkg::FUNC_WRITE;
    live_count    = 0;
    mismatches    = 0;
    items_sent    = 0;
    searches_sent = 0;
    results_seen  = 0;
    settings_used = 0;
    tx_calm       = 0;
    quiet_tail    = 1'b0;
    foreach (shadow_entries[i])
      shadow_entries[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_entry_count(directed_rows[i].value);
      else
        send_request(directed_rows[i].func, directed_rows[i].slot, directed_rows[i].value,
                     directed_rows[i].typed, directed_rows[i].want);
    end

    phase_no = 0;
    while (items_sent < RANDOM_ITEMS + $size(directed_rows)) begin
      run_phase(phase_no);
      phase_no++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d searches), %0d answers checked,",
             items_sent, searches_sent, results_seen);
    $display("over %0d entry_count settings incl. 0, 1, 1024 and 2047.", settings_used);
    if (mismatches == 0)
      $display("sorted_table_binary_search_core test passed");
    else
      $display("sorted_table_binary_search_core test failed");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("TIMEOUT with %0d answers still due", pending_answers.size());
    $display("sorted_table_binary_search_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/stbs_pkg.sv
design/stbs_ram.sv
design/stbs_ctrl.sv
design/stbs_dp.sv
design/sorted_table_binary_search_core.sv
design/stbs_chk.sv
tb/testbench.sv
